// File: sv/pfd_pkg.sv
`default_nettype none
package pfd_pkg;

	localparam int DIGIT_BITS = 16;
	localparam int ALPHA_FRAC = 16;
	localparam int ALPHA_WIDTH = 17;
	localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = 17'h10000;

	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INTEG_GAIN  = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_TARGET      = 3'd3,
		CFG_OUT_LOW     = 3'd4,
		CFG_OUT_HIGH    = 3'd5,
		CFG_SMOOTH_COEF = 3'd6
	} cfg_index_t;

endpackage
`default_nettype wire

// File: sv/pfd_mul.sv
`default_nettype none
module pfd_mul #(
	parameter int A_WIDTH = 33,
	parameter int B_WIDTH = 34,
	localparam int NumDigits = (B_WIDTH + pfd_pkg::DIGIT_BITS - 1) / pfd_pkg::DIGIT_BITS,
	localparam int P_WIDTH = A_WIDTH + NumDigits * pfd_pkg::DIGIT_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [A_WIDTH-1:0] a,
	input  wire logic signed [B_WIDTH-1:0] b,
	output logic                           done,
	output logic signed [P_WIDTH-1:0]      product
);
	import pfd_pkg::*;

	localparam int BX_WIDTH = NumDigits * DIGIT_BITS;
	localparam int CNT_WIDTH = $clog2(NumDigits + 1);
	localparam int PP_WIDTH = A_WIDTH + DIGIT_BITS + 1;

	logic signed [A_WIDTH-1:0]  a_q;
	logic signed [BX_WIDTH-1:0] b_q;
	logic signed [P_WIDTH-1:0]  acc_q;
	logic [CNT_WIDTH-1:0]       cnt_q;
	logic                       first_q;
	logic                       busy_q;
	logic                       done_q;

	logic signed [DIGIT_BITS:0] digit;
	logic signed [PP_WIDTH-1:0] partial;
	logic signed [P_WIDTH-1:0]  acc_next;

	// The multiplier is consumed one 16-bit digit per cycle, most significant digit first.
	// Only the top digit carries the sign.
	always_comb begin
		digit = {first_q ? b_q[BX_WIDTH-1] : 1'b0, b_q[BX_WIDTH-1 -: DIGIT_BITS]};
		partial = a_q * digit;
		acc_next = (acc_q <<< DIGIT_BITS) + P_WIDTH'(partial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			first_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q <= a;
				b_q <= BX_WIDTH'(b);
				acc_q <= '0;
				cnt_q <= CNT_WIDTH'(NumDigits);
				first_q <= 1'b1;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_next;
				b_q <= b_q <<< DIGIT_BITS;
				first_q <= 1'b0;
				cnt_q <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

// File: sv/pid_filtered_derivative_unit.sv
// PID controller with a smoothed derivative term and integral anti-windup.
// Each request on the measurement channel carries one sample; the block answers
// with exactly one request on the drive channel, in order.
// Both channels use valid and ready. The block takes a new measurement only when
// its sequencer is idle; a finished drive value sits in an output register, so the
// next measurement may be taken while the previous drive value is still pending.
// One sample runs ERR, four multiplies and two short add steps on a single shared
// digit-serial multiplier, which takes NumDigits digits of 16 bits per multiply,
// where NumDigits is ceil((DATA_WIDTH + 2) / 16). The next measurement is taken
// only after the sequencer has finished the sample and returned to idle.
// If the receiver stalls, the drive value holds and the last sequencer step waits
// until the output register is free.
// Configuration is written through cfg_write_en, cfg_index and cfg_data while idle;
// the user must keep to that, as the block itself does not enforce it. Reset clears
// the integral, the previous error and the smoothed derivative, sets the gains,
// target and smoothing weight to zero and opens the output limits fully.
`default_nettype none
module pid_filtered_derivative_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16,
	localparam int CfgWidth = (DATA_WIDTH > pfd_pkg::ALPHA_WIDTH) ? DATA_WIDTH :
		pfd_pkg::ALPHA_WIDTH
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write_en,
	input  wire logic [pfd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [CfgWidth-1:0]                   cfg_data,
	input  wire logic                                  measurement_valid,
	output logic                                       measurement_ready,
	input  wire logic signed [DATA_WIDTH-1:0]          measurement,
	output logic                                       drive_valid,
	input  wire logic                                  drive_ready,
	output logic signed [DATA_WIDTH-1:0]               drive
);
	import pfd_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int A_WIDTH = W + 1;
	localparam int B_WIDTH = W + 2;
	localparam int NumDigits = (B_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int P_WIDTH = A_WIDTH + NumDigits * DIGIT_BITS;
	localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_PGO,
		ST_PWAIT,
		ST_IGO,
		ST_IWAIT,
		ST_IACC,
		ST_SGO,
		ST_SWAIT,
		ST_DGO,
		ST_DWAIT,
		ST_SUM
	} state_t;

	logic signed [W-1:0]           prop_gain_q;
	logic signed [W-1:0]           integ_gain_q;
	logic signed [W-1:0]           deriv_gain_q;
	logic signed [W-1:0]           target_q;
	logic signed [W-1:0]           out_low_q;
	logic signed [W-1:0]           out_high_q;
	logic [ALPHA_WIDTH-1:0]        smooth_coef_q;

	state_t                        state_q;
	logic signed [W-1:0]           meas_q;
	logic signed [W-1:0]           err_q;
	logic signed [W-1:0]           draw_q;
	logic signed [W-1:0]           pterm_q;
	logic signed [W-1:0]           term_q;
	logic signed [W-1:0]           integ_acc_q;
	logic signed [W-1:0]           last_error_q;
	logic signed [W-1:0]           smoothed_q;
	logic signed [W-1:0]           drive_q;
	logic                          valid_q;

	logic                          mul_start;
	logic signed [A_WIDTH-1:0]     mul_a;
	logic signed [B_WIDTH-1:0]     mul_b;
	logic                          mul_done;
	logic signed [P_WIDTH-1:0]     mul_product;

	logic [ALPHA_WIDTH-1:0]        alpha_eff;
	logic signed [P_WIDTH-1:0]     prod_shifted;
	logic signed [W-1:0]           prod_sat;
	logic signed [P_WIDTH-1:0]     prod_alpha;
	logic signed [W-1:0]           smoothed_next;
	logic signed [W-1:0]           err_next;
	logic signed [W-1:0]           draw_next;
	logic signed [W-1:0]           integ_next;
	logic signed [W-1:0]           total_next;

	function automatic logic signed [W-1:0] sat1(input logic signed [W:0] x);
		logic signed [W-1:0] r;
		if (x[W] == x[W-1]) begin
			r = x[W-1:0];
		end else begin
			r = x[W] ? VAL_MIN : VAL_MAX;
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] x);
		logic signed [W-1:0] r;
		if ((x[W+1] == x[W]) && (x[W] == x[W-1])) begin
			r = x[W-1:0];
		end else begin
			r = x[W+1] ? VAL_MIN : VAL_MAX;
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] limit(input logic signed [W-1:0] x,
			input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		logic signed [W-1:0] r;
		if (x < lo) begin
			r = lo;
		end else if (x > hi) begin
			r = hi;
		end else begin
			r = x;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			target_q <= '0;
			out_low_q <= VAL_MIN;
			out_high_q <= VAL_MAX;
			smooth_coef_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_PROP_GAIN: begin
					prop_gain_q <= cfg_data[W-1:0];
				end
				CFG_INTEG_GAIN: begin
					integ_gain_q <= cfg_data[W-1:0];
				end
				CFG_DERIV_GAIN: begin
					deriv_gain_q <= cfg_data[W-1:0];
				end
				CFG_TARGET: begin
					target_q <= cfg_data[W-1:0];
				end
				CFG_OUT_LOW: begin
					out_low_q <= cfg_data[W-1:0];
				end
				CFG_OUT_HIGH: begin
					out_high_q <= cfg_data[W-1:0];
				end
				CFG_SMOOTH_COEF: begin
					smooth_coef_q <= cfg_data[ALPHA_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		alpha_eff = (smooth_coef_q > ALPHA_ONE) ? ALPHA_ONE : smooth_coef_q;

		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PGO: begin
				mul_start = 1'b1;
				mul_a = A_WIDTH'(err_q);
				mul_b = B_WIDTH'(prop_gain_q);
			end
			ST_IGO: begin
				mul_start = 1'b1;
				mul_a = A_WIDTH'(err_q);
				mul_b = B_WIDTH'(integ_gain_q);
			end
			ST_SGO: begin
				mul_start = 1'b1;
				mul_a = A_WIDTH'(smoothed_q) - A_WIDTH'(draw_q);
				mul_b = B_WIDTH'(signed'({1'b0, alpha_eff}));
			end
			ST_DGO: begin
				mul_start = 1'b1;
				mul_a = A_WIDTH'(smoothed_q);
				mul_b = B_WIDTH'(deriv_gain_q);
			end
			default: begin
			end
		endcase

		prod_shifted = mul_product >>> FRAC_BITS;
		if ((&prod_shifted[P_WIDTH-1:W-1]) || !(|prod_shifted[P_WIDTH-1:W-1])) begin
			prod_sat = prod_shifted[W-1:0];
		end else begin
			prod_sat = prod_shifted[P_WIDTH-1] ? VAL_MIN : VAL_MAX;
		end

		// The smoothing sum is raw * 1.0 + alpha * (smoothed - raw), so only the
		// alpha product needs the multiplier; the result always fits the word.
		prod_alpha = mul_product >>> ALPHA_FRAC;
		smoothed_next = draw_q + prod_alpha[W-1:0];

		err_next = sat1((W+1)'(target_q) - (W+1)'(meas_q));
		draw_next = sat1((W+1)'(err_q) - (W+1)'(last_error_q));
		integ_next = limit(sat1((W+1)'(integ_acc_q) + (W+1)'(term_q)), out_low_q,
			out_high_q);
		total_next = limit(sat2((W+2)'(pterm_q) + (W+2)'(integ_acc_q) + (W+2)'(term_q)),
			out_low_q, out_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			meas_q <= '0;
			err_q <= '0;
			draw_q <= '0;
			pterm_q <= '0;
			term_q <= '0;
			integ_acc_q <= '0;
			last_error_q <= '0;
			smoothed_q <= '0;
			drive_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && drive_ready && (state_q != ST_SUM)) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (measurement_valid) begin
						meas_q <= measurement;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					err_q <= err_next;
					state_q <= ST_PGO;
				end
				ST_PGO: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (mul_done) begin
						pterm_q <= prod_sat;
						state_q <= ST_IGO;
					end
				end
				ST_IGO: begin
					state_q <= ST_IWAIT;
				end
				ST_IWAIT: begin
					if (mul_done) begin
						term_q <= prod_sat;
						state_q <= ST_IACC;
					end
				end
				ST_IACC: begin
					integ_acc_q <= integ_next;
					draw_q <= draw_next;
					state_q <= ST_SGO;
				end
				ST_SGO: begin
					last_error_q <= err_q;
					state_q <= ST_SWAIT;
				end
				ST_SWAIT: begin
					if (mul_done) begin
						smoothed_q <= smoothed_next;
						state_q <= ST_DGO;
					end
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (mul_done) begin
						term_q <= prod_sat;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (!valid_q || drive_ready) begin
						drive_q <= total_next;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	pfd_mul #(
		.A_WIDTH(A_WIDTH),
		.B_WIDTH(B_WIDTH)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.product(mul_product)
	);

	assign measurement_ready = (state_q == ST_IDLE);
	assign drive_valid = valid_q;
	assign drive = drive_q;

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int DW = 32;
	localparam int FRAC_BITS = 16;
	localparam longint SAT_MAX = (longint'(1) <<< (DW - 1)) - 1;
	localparam longint SAT_MIN = -SAT_MAX - 1;
	localparam logic [DW-1:0] WORD_HI = 32'h7fffffff;
	localparam logic [DW-1:0] WORD_LO = 32'h80000000;
	localparam logic [pfd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 3'd7;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 66;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [pfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic measurement_valid = 1'b0;
	logic measurement_ready;
	logic [DW-1:0] measurement = '0;
	logic drive_valid;
	logic drive_ready = 1'b0;
	logic [DW-1:0] drive;

	pid_filtered_derivative_unit #(
		.DATA_WIDTH(DW),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.measurement_valid(measurement_valid),
		.measurement_ready(measurement_ready),
		.measurement(measurement),
		.drive_valid(drive_valid),
		.drive_ready(drive_ready),
		.drive(drive)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint kp = 0;
	longint ki = 0;
	longint kd = 0;
	longint setpoint = 0;
	longint lim_lo = SAT_MIN;
	longint lim_hi = SAT_MAX;
	logic [pfd_pkg::ALPHA_WIDTH-1:0] coef = '0;
	longint integ_sum = 0;
	longint last_err = 0;
	longint diff_avg = 0;

	logic [DW-1:0] meas_queue[$];
	logic [DW-1:0] drive_expected[$];
	int meas_sent = 0;
	int meas_taken = 0;
	int drives_seen = 0;
	int error_count = 0;
	int settings_count = 0;
	int reg_writes = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stuck_cycles = 0;
	logic [9:0] rx_cycle = '0;
	logic [DW-1:0] want;

	function automatic longint clip_word(longint x);
		if (x > SAT_MAX)
			return SAT_MAX;
		if (x < SAT_MIN)
			return SAT_MIN;
		return x;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return clip_word((a * b) >>> FRAC_BITS);
	endfunction

	function automatic longint bound_out(longint x);
		if (x < lim_lo)
			return lim_lo;
		if (x > lim_hi)
			return lim_hi;
		return x;
	endfunction

	function automatic logic [DW-1:0] predict_drive(logic [DW-1:0] meas_word);
		longint err;
		longint pterm;
		longint draw;
		longint weight;
		longint dterm;
		longint total;
		err = clip_word(setpoint - longint'($signed(meas_word)));
		pterm = fx_mul(kp, err);
		integ_sum = bound_out(clip_word(integ_sum + fx_mul(ki, err)));
		draw = clip_word(err - last_err);
		weight = (coef > pfd_pkg::ALPHA_ONE) ? longint'(pfd_pkg::ALPHA_ONE) : longint'(coef);
		diff_avg = (diff_avg * weight + draw * (longint'(pfd_pkg::ALPHA_ONE) - weight))
			>>> pfd_pkg::ALPHA_FRAC;
		dterm = fx_mul(kd, diff_avg);
		last_err = err;
		total = bound_out(clip_word(pterm + integ_sum + dterm));
		return total[DW-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic set_reg(logic [pfd_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [DW-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		reg_writes++;
		case (idx)
			pfd_pkg::CFG_PROP_GAIN: kp = $signed(data);
			pfd_pkg::CFG_INTEG_GAIN: ki = $signed(data);
			pfd_pkg::CFG_DERIV_GAIN: kd = $signed(data);
			pfd_pkg::CFG_TARGET: setpoint = $signed(data);
			pfd_pkg::CFG_OUT_LOW: lim_lo = $signed(data);
			pfd_pkg::CFG_OUT_HIGH: lim_hi = $signed(data);
			pfd_pkg::CFG_SMOOTH_COEF: coef = data[pfd_pkg::ALPHA_WIDTH-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [DW-1:0] p, logic [DW-1:0] i, logic [DW-1:0] d,
			logic [DW-1:0] tgt, logic [DW-1:0] lo, logic [DW-1:0] hi,
			logic [DW-1:0] coef_word, bit poke_unused);
		set_reg(pfd_pkg::CFG_PROP_GAIN, p);
		set_reg(pfd_pkg::CFG_INTEG_GAIN, i);
		set_reg(pfd_pkg::CFG_DERIV_GAIN, d);
		if (poke_unused)
			set_reg(CFG_UNUSED, $urandom);
		set_reg(pfd_pkg::CFG_TARGET, tgt);
		set_reg(pfd_pkg::CFG_OUT_LOW, lo);
		set_reg(pfd_pkg::CFG_OUT_HIGH, hi);
		set_reg(pfd_pkg::CFG_SMOOTH_COEF, coef_word);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		settings_count++;
		@(negedge clk);
	endtask

	task automatic queue_sample(logic [DW-1:0] meas_word);
		meas_queue.push_back(meas_word);
		meas_sent++;
	endtask

	task automatic wait_drained();
		while (meas_taken != meas_sent || drive_expected.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [DW-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
			2, 3: return 32'($urandom_range(0, 32'h10000)) - 32'h8000;
			4: return $urandom_range(0, 1) ? WORD_HI : WORD_LO;
			default: return '0;
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_coef();
		logic [DW-1:0] junk;
		junk = $urandom;
		case ($urandom_range(0, 5))
			0, 1, 2: return {junk[DW-1:17], 17'($urandom_range(0, 65536))};
			3: return {junk[DW-1:17], 17'($urandom_range(65537, 131071))};
			4: return {junk[DW-1:17], pfd_pkg::ALPHA_ONE};
			default: return {junk[DW-1:17], 17'h0};
		endcase
	endfunction

	task automatic pick_limits(output logic [DW-1:0] lo, output logic [DW-1:0] hi);
		case ($urandom_range(0, 4))
			0: begin
				lo = WORD_LO;
				hi = WORD_HI;
			end
			1, 2: begin
				lo = -32'($urandom_range(32'h8000, 32'h200000));
				hi = 32'($urandom_range(32'h8000, 32'h200000));
			end
			3: begin
				lo = $urandom;
				hi = $urandom;
			end
			default: begin
				lo = 32'($urandom_range(32'h1000, 32'h40000));
				hi = -32'($urandom_range(32'h1000, 32'h40000));
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (measurement_valid && measurement_ready) begin
				drive_expected.push_back(predict_drive(measurement));
				meas_taken++;
			end
			if (!measurement_valid || measurement_ready) begin
				if (gap_left > 0 || meas_queue.size() == 0) begin
					measurement_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					measurement_valid <= 1'b1;
					measurement <= meas_queue.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(20, 40);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 6);
						gap_left = $urandom_range(1, 60);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (drive_valid && drive_ready) begin
				drives_seen++;
				if (drive_expected.size() == 0) begin
					report_mismatch($sformatf("drive %h arrived with no measurement pending", drive));
				end else begin
					want = drive_expected.pop_front();
					if (drive !== want)
						report_mismatch($sformatf("drive #%0d: got %h, expected %h",
							drives_seen, drive, want));
				end
			end
			rx_cycle <= rx_cycle + 1'b1;
			case (rx_cycle[8:7])
				2'd0: drive_ready <= 1'b1;
				2'd1: drive_ready <= $urandom_range(0, 1);
				2'd2: drive_ready <= ($urandom_range(0, 12) == 0);
				default: drive_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write_en || (measurement_valid && measurement_ready)
				|| (drive_valid && drive_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles.", STUCK_LIMIT);
			$display("FAIL pid_filtered_derivative_unit");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [DW-1:0] tgt;
		logic [DW-1:0] lo;
		logic [DW-1:0] hi;
		logic [DW-1:0] offset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers still hold their reset values, so every drive must be zero.
		queue_sample('0);
		queue_sample(WORD_LO);
		queue_sample(WORD_HI);
		queue_sample(32'h00010000);
		wait_drained();

		// The error and the raw derivative both saturate on full-scale swings.
		program_all(32'h00010000, 32'h00008000, 32'h00020000, WORD_HI, WORD_LO, WORD_HI,
			32'h0, 1'b0);
		queue_sample(WORD_LO);
		queue_sample(WORD_HI);
		queue_sample('0);
		queue_sample(WORD_LO);
		queue_sample(32'hffffffff);
		wait_drained();

		// Crossed output limits, products that saturate, and full smoothing.
		program_all(WORD_HI, WORD_HI, WORD_LO, WORD_LO, 32'h00010000, 32'hffff0000,
			{15'h7fff, pfd_pkg::ALPHA_ONE}, 1'b0);
		queue_sample(WORD_HI);
		queue_sample(WORD_LO);
		queue_sample('0);
		queue_sample(32'h00003039);
		wait_drained();

		// A smoothing weight above one and a write to the unused index.
		program_all(WORD_LO, 32'hfffff000, WORD_HI, 32'h00030000, 32'hfffb0000, 32'h00050000,
			32'hffffffff, 1'b1);
		queue_sample(32'h00040000);
		queue_sample(32'h00020000);
		queue_sample(32'hfff00000);
		queue_sample(32'h00030000);
		queue_sample($urandom);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			tgt = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h100000)) - 32'h80000;
			pick_limits(lo, hi);
			wait_drained();
			program_all(rand_gain(), rand_gain(), rand_gain(), tgt, lo, hi, rand_coef(),
				$urandom_range(0, 1));
			offset = '0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 19))
					0, 1: queue_sample($urandom);
					2: queue_sample($urandom_range(0, 1) ? WORD_HI : WORD_LO);
					default: begin
						offset = offset + 32'($urandom_range(0, 32'h10000)) - 32'h8000;
						queue_sample(tgt + offset);
					end
				endcase
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (drive_expected.size() != 0)
			report_mismatch($sformatf("%0d drive values never arrived", drive_expected.size()));
		$display("Sent %0d measurements and checked %0d drive values over %0d register settings.",
			meas_taken, drives_seen, settings_count);
		$display("%0d register writes covered open, narrow and crossed limits and weights past one.",
			reg_writes);
		if (error_count == 0)
			$display("PASS pid_filtered_derivative_unit");
		else
			$display("FAIL pid_filtered_derivative_unit");
		$finish;
	end

endmodule

// File: sim.f
sv/pfd_pkg.sv
sv/pfd_mul.sv
sv/pid_filtered_derivative_unit.sv
test/tb_top.sv
